// ===== rtl/window_pacing_rate_limiter_assert.svh =====
// Assertion macros shared by the rate limiter modules.
`ifndef WINDOW_PACING_RATE_LIMITER_ASSERT_SVH
`define WINDOW_PACING_RATE_LIMITER_ASSERT_SVH

// Check an implication at every clock edge outside reset.
`define WPRL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check an implication at every clock edge, reset included.
`define WPRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wprl_pkg.sv =====
package wprl_pkg;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int CFG_W      = 32;
    localparam int DELAY_W    = 42;
    localparam int PROD_W     = 42;
    localparam int DIV_W      = (TIME_W > PROD_W) ? TIME_W : PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int S_DATA_W   = ((TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((DELAY_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 1;

    // Constants
    localparam logic [CFG_W-1:0] DEFAULT_RATE = 32'd100000;
    localparam logic [CFG_W-1:0] RESET_WIN_MS = 32'd1000;
    localparam logic [9:0]       MS_PER_S     = 10'd1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPS_PER_SECOND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input time stamp
        logic div_start;   // launch the divider
        logic div_sel;     // 0: time / window, 1: product / rate
        logic upd_new;     // open a new window
        logic upd_cont;    // count one more op in this window
        logic mul_count;   // product = count * 1000
        logic cap_due;     // latch saturated due time
        logic cap_diff;    // latch due minus walk
        logic mul_delay;   // delay = diff * 1000
        logic out_load;    // move the result to the output register
    } wprl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic new_win;
        logic out_free;
    } wprl_stat_t;

endpackage

// ===== rtl/wprl_div.sv =====
module wprl_div
    import wprl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot,
    output logic [CFG_W-1:0] rem
);

    `include "window_pacing_rate_limiter_assert.svh"

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     divisor_reg;

    logic [CFG_W:0]       trial;
    logic                 ge;
    logic [CFG_W:0]       diff;
    logic [CFG_W-1:0]     rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quot_reg[DIV_W-1]};
        ge       = (trial >= {1'b0, divisor_reg});
        diff     = trial - {1'b0, divisor_reg};
        rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the bottom as dividend bits leave the top
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    `WPRL_ASSERT_RST(a_no_restart, aclk, aresetn, start |-> !busy_reg, "divider restarted while busy")

endmodule

// ===== rtl/wprl_datapath.sv =====
module wprl_datapath
    import wprl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wprl_cmd_t            cmd,
    output wprl_stat_t           stat,
    input  logic [TIME_W-1:0]    time_in,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 cfg_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DELAY_W-1:0]   m_delay,
    output logic                 m_new
);

    `include "window_pacing_rate_limiter_assert.svh"

    logic [CFG_W-1:0]   ops_reg;
    logic [CFG_W-1:0]   win_reg;
    logic [TIME_W-1:0]  window_index_reg;
    logic [CFG_W-1:0]   op_count_reg;
    logic               m_valid_reg;

    logic [TIME_W-1:0]  t_reg;
    logic [CFG_W-1:0]   walk_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CFG_W-1:0]   due_reg;
    logic [CFG_W-1:0]   diff_reg;
    logic [DELAY_W-1:0] res_delay_reg;
    logic               res_new_reg;
    logic [DELAY_W-1:0] m_delay_reg;
    logic               m_new_reg;

    logic [CFG_W-1:0]   rate;
    logic [CFG_W-1:0]   win;
    logic [DIV_W-1:0]   div_dividend;
    logic [CFG_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [CFG_W-1:0]   div_rem;

    // Substitute the default rate for a zero rate and 1 for a zero window
    assign rate = (ops_reg == '0) ? DEFAULT_RATE : ops_reg;
    assign win  = (win_reg == '0) ? CFG_W'(1) : win_reg;

    // Share one divider between both divisions
    assign div_dividend = cmd.div_sel ? DIV_W'(prod_reg) : DIV_W'(t_reg);
    assign div_divisor  = cmd.div_sel ? rate : win;

    wprl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign stat.div_done = div_done;
    assign stat.new_win  = (div_quot[TIME_W-1:0] != window_index_reg);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign cfg_ready = 1'b1;

    // Configuration, window state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops_reg          <= DEFAULT_RATE;
            win_reg          <= RESET_WIN_MS;
            window_index_reg <= '0;
            op_count_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_OPS_PER_SECOND: ops_reg <= cfg_data;
                    REG_WINDOW_MS:      win_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.upd_new) begin
                window_index_reg <= div_quot[TIME_W-1:0];
                op_count_reg     <= CFG_W'(1);
            end else if (cmd.upd_cont) begin
                if (op_count_reg != '1) begin
                    op_count_reg <= op_count_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers for one request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            t_reg <= time_in;
        end
        if (cmd.upd_cont) begin
            walk_reg <= div_rem;
        end
        if (cmd.mul_count) begin
            prod_reg <= PROD_W'(op_count_reg) * PROD_W'(MS_PER_S);
        end
        if (cmd.cap_due) begin
            due_reg <= (|div_quot[DIV_W-1:CFG_W]) ? '1 : div_quot[CFG_W-1:0];
        end
        if (cmd.cap_diff) begin
            diff_reg <= (due_reg > walk_reg) ? (due_reg - walk_reg) : '0;
        end
        if (cmd.upd_new) begin
            res_delay_reg <= '0;
            res_new_reg   <= 1'b1;
        end else if (cmd.mul_delay) begin
            res_delay_reg <= DELAY_W'(diff_reg) * DELAY_W'(MS_PER_S);
            res_new_reg   <= 1'b0;
        end
        if (cmd.out_load) begin
            m_delay_reg <= res_delay_reg;
            m_new_reg   <= res_new_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_delay = m_delay_reg;
    assign m_new   = m_new_reg;

    `WPRL_ASSERT_RST(a_load_when_free, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready), "result overwritten before taken")
    `WPRL_ASSERT_RST(a_new_window, aclk, aresetn, cmd.upd_new |=> (op_count_reg == CFG_W'(1) && window_index_reg == $past(div_quot[TIME_W-1:0])), "new window not stored")

endmodule

// ===== rtl/wprl_ctrl.sv =====
module wprl_ctrl
    import wprl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  wprl_stat_t stat,
    output wprl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DIV1_GO   = 4'd1;
    localparam logic [3:0] ST_DIV1_WAIT = 4'd2;
    localparam logic [3:0] ST_MUL1      = 4'd3;
    localparam logic [3:0] ST_DIV2_GO   = 4'd4;
    localparam logic [3:0] ST_DIV2_WAIT = 4'd5;
    localparam logic [3:0] ST_DUE       = 4'd6;
    localparam logic [3:0] ST_DIFF      = 4'd7;
    localparam logic [3:0] ST_MUL2      = 4'd8;
    localparam logic [3:0] ST_OUT       = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence one request through the datapath
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: begin
                if (stat.div_done) begin
                    if (stat.new_win) begin
                        cmd.upd_new = 1'b1;
                        state_next  = ST_OUT;
                    end else begin
                        cmd.upd_cont = 1'b1;
                        state_next   = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                cmd.mul_count = 1'b1;
                state_next    = ST_DIV2_GO;
            end
            ST_DIV2_GO: begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.cap_due = 1'b1;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.cap_diff = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_delay = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/window_pacing_rate_limiter.sv =====
// Channel   Direction  Beat contents
// s_        in         tdata: time_ms[47:0]
// m_        out        tdata: delay_us[41:0], zero pad; tuser: new_window
// cfg_      in         index 0 ops_per_second, index 1 window_ms; cfg_data 32 bits
//
// One request at a time: a request that opens a new window runs one division,
// any other runs two divisions plus the multiply and subtract steps.
// The bit-serial divider works one quotient bit per cycle.
// Synchronous active-low reset; no clearing pass is needed.
// A result waits in the output register while the next request is taken in.
module window_pacing_rate_limiter
    import wprl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // time_ms
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // delay_us, zero pad
    output logic                 m_tuser,   // new_window
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    wprl_cmd_t          cmd;
    wprl_stat_t         stat;
    logic [DELAY_W-1:0] m_delay;

    wprl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wprl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .time_in   (s_tdata[TIME_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_delay   (m_delay),
        .m_new     (m_tuser)
    );

    assign m_tdata = M_DATA_W'(m_delay);

endmodule

// ===== test/wprl_pace_checker.sv =====
// Watches the request, result and register channels of the rate limiter,
// predicts every result and compares it with what the block returns.
module wprl_pace_checker
    import wprl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // time_ms
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,   // delay_us, zero pad
    input  logic                 m_tuser,   // new_window
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   results_seen,
    output int                   windows_opened,
    output int                   delays_seen
);

    typedef struct packed {
        logic [DELAY_W-1:0] delay_us;
        logic               new_window;
    } pace_t;

    pace_t             due_delays[$];
    logic [CFG_W-1:0]  rate_reg;
    logic [CFG_W-1:0]  win_reg;
    logic [TIME_W-1:0] cur_index;
    logic [31:0]       op_count;
    int                shown;

    initial begin
        errors         = 0;
        pending        = 0;
        results_seen   = 0;
        windows_opened = 0;
        delays_seen    = 0;
        shown          = 0;
    end

    // Work out the pacing delay for one request and queue it
    task automatic pace_request(input logic [TIME_W-1:0] stamp);
        logic [63:0] win;
        logic [63:0] rate;
        logic [63:0] idx;
        logic [63:0] walk;
        logic [63:0] due;
        logic [63:0] delay;
        pace_t       p;
        win  = (win_reg == '0) ? 64'd1 : 64'(win_reg);
        rate = (rate_reg == '0) ? 64'(DEFAULT_RATE) : 64'(rate_reg);
        idx  = 64'(stamp) / win;
        if (idx[TIME_W-1:0] != cur_index) begin
            cur_index    = idx[TIME_W-1:0];
            op_count     = 32'd1;
            p.delay_us   = '0;
            p.new_window = 1'b1;
        end else begin
            // saturate the count, then compare due time with time spent
            if (op_count != 32'hFFFF_FFFF)
                op_count = op_count + 32'd1;
            walk = 64'(stamp) % win;
            due  = (64'(op_count) * 64'(MS_PER_S)) / rate;
            if (due > 64'hFFFF_FFFF)
                due = 64'hFFFF_FFFF;
            delay        = (due > walk) ? (due - walk) * 64'(MS_PER_S) : 64'd0;
            p.delay_us   = delay[DELAY_W-1:0];
            p.new_window = 1'b0;
        end
        due_delays.push_back(p);
    endtask

    // Compare one result beat with the oldest queued delay
    task automatic check_beat();
        pace_t              want;
        logic [DELAY_W-1:0] got_delay;
        got_delay = m_tdata[DELAY_W-1:0];
        results_seen++;
        if (m_tuser)
            windows_opened++;
        if (got_delay != '0)
            delays_seen++;
        if (due_delays.size() == 0) begin
            errors++;
            if (shown < 40)
                $display("%0t: result beat with nothing queued, delay_us %0d new_window %0b",
                         $time, got_delay, m_tuser);
            shown++;
            return;
        end
        want = due_delays.pop_front();
        if (got_delay != want.delay_us) begin
            errors++;
            if (shown < 40)
                $display("%0t: delay_us expected %0d actual %0d",
                         $time, want.delay_us, got_delay);
            shown++;
        end
        if (m_tuser != want.new_window) begin
            errors++;
            if (shown < 40)
                $display("%0t: new_window expected %0b actual %0b",
                         $time, want.new_window, m_tuser);
            shown++;
        end
    endtask

    // Track registers and requests, check results
    always @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  = DEFAULT_RATE;
            win_reg   = RESET_WIN_MS;
            cur_index = '0;
            op_count  = '0;
            due_delays.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OPS_PER_SECOND: rate_reg = cfg_data;
                    REG_WINDOW_MS:      win_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                pace_request(s_tdata[TIME_W-1:0]);
        end
        pending = due_delays.size();
    end

endmodule

// ===== test/window_pacing_rate_limiter_tb.sv =====
module window_pacing_rate_limiter_tb;
    import wprl_pkg::*;

    localparam int                CYCLE_LIMIT = 600000;
    localparam int                PHASE_ITEMS = 125;
    localparam logic [63:0]       TIME_MAX    = (64'd1 << TIME_W) - 64'd1;
    localparam logic [CFG_W-1:0]  CFG_MAX     = '1;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int   errors;
    int   pending;
    int   results_seen;
    int   windows_opened;
    int   delays_seen;
    int   cycles      = 0;
    int   items_sent  = 0;
    int   settings    = 0;
    logic quiet       = 1'b0;
    logic stall_req   = 1'b0;
    logic [63:0] cur_win   = 64'd1000;
    logic [63:0] last_time = 64'd0;

    window_pacing_rate_limiter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wprl_pace_checker pace_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .results_seen   (results_seen),
        .windows_opened (windows_opened),
        .delays_seen    (delays_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: one long hold-off on request, random stall bursts otherwise
    initial begin
        int hold_left;
        int idle_left;
        bit stall_taken;
        hold_left   = 0;
        idle_left   = 0;
        stall_taken = 0;
        forever begin
            @(negedge aclk);
            if (stall_req && !stall_taken) begin
                stall_taken = 1;
                hold_left   = 1000;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else if (!quiet && aresetn && $urandom_range(0, 15) == 0) begin
                m_tready  <= 1'b0;
                idle_left = $urandom_range(1, 12) - 1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // Offer one request and hold it until taken
    task automatic push_time(input logic [63:0] stamp);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(stamp[TIME_W-1:0]);
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid for a random burst
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 12);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Stop offering and wait for every queued result
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then load a rate and a window length
    task automatic set_pacing(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] win);
        drain();
        write_reg(REG_OPS_PER_SECOND, rate);
        write_reg(REG_WINDOW_MS, win);
        cur_win = (win == '0) ? 64'd1 : 64'(win);
        settings++;
    endtask

    // Mostly requests in the current window, some in the next, some anywhere
    function automatic logic [63:0] pick_time();
        logic [63:0] rnd;
        logic [63:0] base;
        logic [63:0] stamp;
        int          mode;
        rnd  = {$urandom, $urandom} & TIME_MAX;
        base = (last_time / cur_win) * cur_win;
        mode = $urandom_range(0, 99);
        if (mode < 55)
            stamp = base + rnd % cur_win;
        else if (mode < 70)
            stamp = base + cur_win + rnd % cur_win;
        else if (mode < 80)
            stamp = rnd % (cur_win * 4);
        else if (mode < 94)
            stamp = rnd;
        else
            stamp = $urandom_range(0, 1) ? TIME_MAX : 64'd0;
        if (stamp > TIME_MAX)
            stamp = TIME_MAX;
        last_time = stamp;
        return stamp;
    endfunction

    initial begin
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] win;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: window 0 continues, then window edges and the top stamp
        push_time(64'd0);
        push_time(64'd5);
        push_time(64'd999);
        push_time(64'd1000);
        push_time(64'd1000);
        push_time(TIME_MAX);
        push_time(TIME_MAX);

        // Zero rate picks the default, zero window acts as 1 ms
        set_pacing('0, '0);
        push_time(64'd7);
        push_time(64'd7);
        push_time(64'd8);

        // Slowest rate with the longest window: large delays
        set_pacing(32'd1, CFG_MAX);
        push_time(64'd0);
        push_time(64'd0);
        push_time(64'd1);
        push_time(64'hFFFF_FFFE);
        push_time(64'hFFFF_FFFF);
        push_time(TIME_MAX);

        // Fastest rate with the shortest window
        set_pacing(CFG_MAX, 32'd1);
        push_time(64'd3);
        push_time(64'd3);
        push_time(64'd3);

        // Due time overtaking the walk inside a short window
        set_pacing(32'd1000, 32'd10);
        push_time(64'd20);
        push_time(64'd21);
        push_time(64'd22);
        push_time(64'd25);

        // Random phases over several settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin rate = $urandom_range(1, 20);     win = $urandom_range(1, 50);   end
                1: begin rate = CFG_MAX;                   win = 32'd1;                   end
                2: begin rate = 32'd1;                     win = CFG_MAX;                 end
                3: begin rate = '0;                        win = $urandom_range(1, 1000); end
                4: begin rate = $urandom_range(100, 5000); win = $urandom_range(10, 3000); end
                5: begin rate = $urandom;                  win = $urandom | 32'd1;        end
                6: begin rate = $urandom_range(1, 1000);   win = $urandom_range(1, 20);   end
                default: begin rate = DEFAULT_RATE;        win = RESET_WIN_MS;            end
            endcase
            set_pacing(rate, win);
            if (p == 3)
                stall_req <= 1'b1;
            if (p == 7)
                quiet <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                push_time(pick_time());
                if (!quiet && $urandom_range(0, 2) == 0)
                    sender_gap();
            end
        end

        // Let the last results out and watch for strays
        drain();
        repeat (200) @(negedge aclk);

        $display("Sent %0d requests over %0d rate and window settings, one long output stall.",
                 items_sent, settings);
        $display("Checked %0d results: %0d opened a window, %0d carried a delay.",
                 results_seen, windows_opened, delays_seen);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
